// File: rtl/core/crcpm_pkg.sv
// ----------------------------------------------------------------------------
// crcpm_pkg
// shared constants, payload types and a bitwise crc-32 helper
// ----------------------------------------------------------------------------
package crcpm_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

    // one message byte request as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic [CRC_W-1:0]  expected_crc;
        logic              expected_parity;
    } t_in_item;

    // one check result
    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             parity_bit;
        logic             mismatch;
    } t_out_item;

    // what the update logic hands back to the control in the top level
    typedef struct packed {
        logic [CRC_W-1:0] next_crc;
        logic             next_parity;
        t_out_item        result;
    } t_upd;

    // reflected crc-32, one byte, eight shift steps unrolled
    function automatic logic [CRC_W-1:0] crc_byte_update(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/crcpm_if.sv
// ----------------------------------------------------------------------------
// crcpm interfaces
// valid/ready channels for message bytes and check results
// ----------------------------------------------------------------------------
interface crcpm_in_if;
    logic                          valid;
    logic                          ready;
    logic [crcpm_pkg::BYTE_W-1:0]  data_byte;
    logic                          last_byte;
    logic [crcpm_pkg::CRC_W-1:0]   expected_crc;
    logic                          expected_parity;

    modport source (
        output valid, data_byte, last_byte, expected_crc, expected_parity,
        input  ready
    );
    modport sink (
        input  valid, data_byte, last_byte, expected_crc, expected_parity,
        output ready
    );
endinterface

interface crcpm_out_if;
    logic                        valid;
    logic                        ready;
    logic [crcpm_pkg::CRC_W-1:0] crc_value;
    logic                        parity_bit;
    logic                        mismatch;

    modport source (
        output valid, crc_value, parity_bit, mismatch,
        input  ready
    );
    modport sink (
        input  valid, crc_value, parity_bit, mismatch,
        output ready
    );
endinterface

// File: rtl/core/crcpm_update.sv
// ----------------------------------------------------------------------------
// crcpm_update
// one-byte crc-32 and parity step, final inversion and expected-value compare
// ----------------------------------------------------------------------------
module crcpm_update (
    input  logic [crcpm_pkg::CRC_W-1:0] i_crc,
    input  logic                        i_parity,
    input  crcpm_pkg::t_in_item         i_item,
    output crcpm_pkg::t_upd             o_upd
);
    import crcpm_pkg::*;

    logic [CRC_W-1:0] crc_next;
    logic             par_next;
    logic [CRC_W-1:0] crc_final;

    assign crc_next  = crc_byte_update(i_crc, i_item.data_byte);
    assign par_next  = i_parity ^ (^i_item.data_byte);
    assign crc_final = crc_next ^ CRC_XOROUT;

    assign o_upd.next_crc          = crc_next;
    assign o_upd.next_parity       = par_next;
    assign o_upd.result.crc_value  = crc_final;
    assign o_upd.result.parity_bit = par_next;
    assign o_upd.result.mismatch   = (crc_final != i_item.expected_crc)
                                  || (par_next != i_item.expected_parity);

endmodule

// File: rtl/core/crc32_parity_message_check.sv
// ----------------------------------------------------------------------------
// crc32_parity_message_check
// running reflected crc-32 and even parity over a byte stream, checked on
// the last byte of each message
// ----------------------------------------------------------------------------
// Takes one message byte per cycle, sustained while no last byte waits on an
// untaken result, and gives one result per message on the cycle after its
// last byte leaves the input register: the crc-32 (poly 0xEDB88320, init and
// xorout all ones), the parity of all data bits, and a mismatch flag against
// the expected crc and parity carried with the last byte. A byte is folded
// into the running state as it leaves the input register; a last byte loads
// the result register and restarts the running state. The byte rate comes
// from the combinational eight-step crc update between the input register
// and the running state. A result in the output register does not stop
// non-last bytes; only a further last byte waits for it to be taken.
// ----------------------------------------------------------------------------
module crc32_parity_message_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crcpm_in_if.sink    i_msg,
    crcpm_out_if.source o_res
);
    import crcpm_pkg::*;

    // input register
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      n_s1_valid;
    t_in_item  n_s1_item;

    // running state
    logic [CRC_W-1:0] r_crc;
    logic             r_parity;
    logic [CRC_W-1:0] n_crc;
    logic             n_parity;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      n_out_valid;
    t_out_item n_out_item;

    t_upd      upd;
    t_in_item  in_item;
    logic      s1_adv;
    logic      in_take;

    assign in_item.data_byte       = i_msg.data_byte;
    assign in_item.last_byte       = i_msg.last_byte;
    assign in_item.expected_crc    = i_msg.expected_crc;
    assign in_item.expected_parity = i_msg.expected_parity;

    crcpm_update u_update (
        .i_crc    (r_crc),
        .i_parity (r_parity),
        .i_item   (r_s1_item),
        .o_upd    (upd)
    );

    // a byte leaves the input register unless it is last and the result
    // register still holds an untaken result
    assign s1_adv = r_s1_valid
                 && (!r_s1_item.last_byte || !r_out_valid || o_res.ready);

    assign i_msg.ready = !r_s1_valid || s1_adv;
    assign in_take     = i_msg.valid && i_msg.ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_item   = r_s1_item;
        n_crc       = r_crc;
        n_parity    = r_parity;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        // result taken downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (s1_adv) begin
            n_s1_valid = 1'b0;
            if (r_s1_item.last_byte) begin
                // message closes: present result, restart running state
                n_out_valid = 1'b1;
                n_out_item  = upd.result;
                n_crc       = CRC_INIT;
                n_parity    = 1'b0;
            end else begin
                n_crc    = upd.next_crc;
                n_parity = upd.next_parity;
            end
        end

        if (in_take) begin
            n_s1_valid = 1'b1;
            n_s1_item  = in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
            r_parity    <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
            r_parity    <= n_parity;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_s1_item  <= n_s1_item;
        r_out_item <= n_out_item;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.crc_value  = r_out_item.crc_value;
    assign o_res.parity_bit = r_out_item.parity_bit;
    assign o_res.mismatch   = r_out_item.mismatch;

endmodule
